FILE: rtl/fsd_pkg.sv
// ----------------------------------------------------------------------------
// fsd_pkg: shared types and constants for the force stillness detector
// Window geometry, arithmetic widths and the item structs used on the ports.
// ----------------------------------------------------------------------------
package fsd_pkg;

    localparam int WINDOW      = 16;
    localparam int NUM_CH      = 4;
    localparam int SAMPLE_W    = 16;
    localparam int LIMIT_W     = 16;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd256;

    localparam int WIN_LOG     = $clog2(WINDOW);
    localparam int POS_W       = WIN_LOG;
    localparam int FILL_W      = $clog2(WINDOW + 1);

    // Arithmetic widths: every sum below is exact.
    localparam int SUM_W       = SAMPLE_W + WIN_LOG + 1;
    localparam int MAG_W       = SUM_W - 1;
    localparam int SQ_W        = 2 * SAMPLE_W;
    localparam int SQS_W       = 2 * SAMPLE_W - 1 + WIN_LOG;
    localparam int SCALED_W    = SQS_W + WIN_LOG;
    localparam int MAGSQ_W     = 2 * MAG_W;
    localparam int BOUND_W     = LIMIT_W + WIN_LOG;
    localparam int BOUND_SQ_W  = 2 * BOUND_W;
    localparam int CMP_W0      = (SCALED_W > MAGSQ_W) ? SCALED_W : MAGSQ_W;
    localparam int CMP_W       = (CMP_W0 > BOUND_SQ_W) ? CMP_W0 : BOUND_SQ_W;

    // Stages from acceptance to the per-lane steady flag.
    localparam int PIPE_STAGES = 5;

    localparam int FIFO_DEPTH  = 8;
    localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] force_front_left;
        logic signed [SAMPLE_W-1:0] force_front_right;
        logic signed [SAMPLE_W-1:0] force_rear_left;
        logic signed [SAMPLE_W-1:0] force_rear_right;
        logic                       accel_small;
    } in_item_t;

    typedef struct packed {
        logic all_steady;
        logic zero_velocity;
        logic windows_full;
    } out_item_t;

    typedef struct packed {
        logic             accept;
        logic             full_before;
        logic [POS_W-1:0] pos;
    } lane_ctrl_t;

    typedef struct packed {
        logic valid;
        logic accel;
        logic full;
    } pipe_tag_t;

endpackage

FILE: rtl/four_channel_force_stillness_detector.sv
// ----------------------------------------------------------------------------
// four_channel_force_stillness_detector: foot force stillness detector
// Four parallel lanes test the sliding-window variance of each foot force
// channel; a merging stage forms the steady and zero-velocity flags.
// ----------------------------------------------------------------------------
// Usage:
// An input item (four signed force samples and the small-acceleration flag)
// is taken on in_data when in_valid is high and in_stall is low. Every item
// gives exactly one result item on out_data, handed over when out_valid is
// high and out_stall is low. The stddev_limit register is written through
// cfg_valid/cfg_data; cfg_ready is always high, and writes belong in idle
// periods only.
// Throughput is one item per clock cycle while in_stall is low, set by the
// single read and write of each lane's ring buffer per item. Before a result
// becomes visible on out_valid, its item passes through the ring buffer read,
// squaring, running-sum update, scaling and squaring of the sum, then the
// compare, followed by the merge into the result queue.
// When the receiver stalls, results collect in an eight-entry queue; in_stall
// rises once eight items are outstanding and no item is ever lost.
// Reset clears the window, the running sums and the queue and sets the limit
// to 256; the first results report windows_full low until 16 items are in.
// ----------------------------------------------------------------------------
module four_channel_force_stillness_detector (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  fsd_pkg::in_item_t                 in_data,
    output logic                              out_valid,
    input  logic                              out_stall,
    output fsd_pkg::out_item_t                out_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [fsd_pkg::LIMIT_W-1:0]       cfg_data
);
    import fsd_pkg::*;

    logic [LIMIT_W-1:0]     limit_reg;
    logic [BOUND_W-1:0]     bound_reg;
    logic [BOUND_SQ_W-1:0]  bound_sq_reg;

    logic [POS_W-1:0]       pos_reg;
    logic [FILL_W-1:0]      fill_reg;
    logic [FIFO_CNT_W-1:0]  inflight_reg;
    pipe_tag_t              pipe_reg [PIPE_STAGES];

    logic                   in_accept;
    logic                   out_accept;
    logic                   full_before;
    logic                   full_now;
    lane_ctrl_t             lane_ctrl;
    logic signed [SAMPLE_W-1:0] lane_sample [NUM_CH];
    logic [NUM_CH-1:0]      lane_steady;
    logic                   merged_steady;
    out_item_t              merged_item;

    assign cfg_ready  = 1'b1;
    assign in_stall   = (inflight_reg == FIFO_CNT_W'(FIFO_DEPTH));
    assign in_accept  = in_valid && !in_stall;
    assign out_accept = out_valid && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            limit_reg <= cfg_data;
        end
    end

    // The squared bound is registered through bound_reg and bound_sq_reg and settles
    // well before any item accepted after a write reaches the compare stage.
    always_ff @(posedge clk)
    begin
        bound_reg    <= BOUND_W'(limit_reg) * BOUND_W'(WINDOW);
        bound_sq_reg <= bound_reg * bound_reg;
    end

    assign full_before = (fill_reg == FILL_W'(WINDOW));
    assign full_now    = full_before || (fill_reg == FILL_W'(WINDOW - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            fill_reg     <= '0;
            inflight_reg <= '0;
        end
        else
        begin
            if (in_accept)
            begin
                pos_reg <= (pos_reg == POS_W'(WINDOW - 1)) ? '0 : pos_reg + 1'b1;
                if (!full_before)
                begin
                    fill_reg <= fill_reg + 1'b1;
                end
            end
            if (in_accept && !out_accept)
            begin
                inflight_reg <= inflight_reg + 1'b1;
            end
            else if (out_accept && !in_accept)
            begin
                inflight_reg <= inflight_reg - 1'b1;
            end
        end
    end

    // Item tags travel alongside the lanes so the merge sees them aligned
    // with the steady flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PIPE_STAGES; i++)
            begin
                pipe_reg[i] <= '0;
            end
        end
        else
        begin
            pipe_reg[0].valid <= in_accept;
            pipe_reg[0].accel <= in_data.accel_small;
            pipe_reg[0].full  <= full_now;
            for (int i = 1; i < PIPE_STAGES; i++)
            begin
                pipe_reg[i] <= pipe_reg[i-1];
            end
        end
    end

    assign lane_ctrl.accept      = in_accept;
    assign lane_ctrl.full_before = full_before;
    assign lane_ctrl.pos         = pos_reg;

    assign lane_sample[0] = in_data.force_front_left;
    assign lane_sample[1] = in_data.force_front_right;
    assign lane_sample[2] = in_data.force_rear_left;
    assign lane_sample[3] = in_data.force_rear_right;

    for (genvar g = 0; g < NUM_CH; g++)
    begin : g_lane
        fsd_lane u_lane (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (lane_ctrl),
            .sample   (lane_sample[g]),
            .bound_sq (bound_sq_reg),
            .steady   (lane_steady[g])
        );
    end

    // Merge: steady only counts once every window is full.
    assign merged_steady             = pipe_reg[PIPE_STAGES-1].full && (&lane_steady);
    assign merged_item.all_steady    = merged_steady;
    assign merged_item.zero_velocity = merged_steady && pipe_reg[PIPE_STAGES-1].accel;
    assign merged_item.windows_full  = pipe_reg[PIPE_STAGES-1].full;

    fsd_out_fifo u_out_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (pipe_reg[PIPE_STAGES-1].valid),
        .wr_data  (merged_item),
        .rd_valid (out_valid),
        .rd_stall (out_stall),
        .rd_data  (out_data)
    );

`ifndef NO_ASSERTIONS
    a_inflight_bound: assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg <= FIFO_CNT_W'(FIFO_DEPTH))
        else $error("outstanding item count exceeds the result queue depth");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(WINDOW))
        else $error("fill count exceeds the window length");

    a_result_has_item: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (inflight_reg != '0))
        else $error("result offered with no outstanding item");

    a_flag_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((!out_data.all_steady || out_data.windows_full) &&
                       (!out_data.zero_velocity || out_data.all_steady)))
        else $error("result flags are inconsistent");
`endif

endmodule

FILE: rtl/fsd_lane.sv
// ----------------------------------------------------------------------------
// fsd_lane: one force channel of the stillness detector
// Ring buffer of the last WINDOW samples, running sum and sum of squares,
// and the exact variance-against-limit test.
// ----------------------------------------------------------------------------
module fsd_lane (
    input  logic                               clk,
    input  logic                               rst_n,
    input  fsd_pkg::lane_ctrl_t                ctrl,
    input  logic signed [fsd_pkg::SAMPLE_W-1:0] sample,
    input  logic [fsd_pkg::BOUND_SQ_W-1:0]     bound_sq,
    output logic                               steady
);
    import fsd_pkg::*;

    logic signed [SAMPLE_W-1:0] hist_mem [WINDOW];

    logic                       v1_reg;
    logic                       v2_reg;
    logic signed [SAMPLE_W-1:0] old_reg;
    logic signed [SAMPLE_W-1:0] new_reg;
    logic                       full_reg;

    logic signed [SAMPLE_W-1:0] old2_reg;
    logic signed [SAMPLE_W-1:0] new2_reg;
    logic [SQ_W-1:0]            sq_old_reg;
    logic [SQ_W-1:0]            sq_new_reg;

    logic signed [SUM_W-1:0]    sum_reg;
    logic signed [SUM_W-1:0]    sum_next;
    logic [SQS_W-1:0]           sumsq_reg;
    logic [SQS_W-1:0]           sumsq_next;

    logic [SCALED_W-1:0]        scaled_reg;
    logic [MAGSQ_W-1:0]         magsq_reg;
    logic                       steady_reg;

    logic signed [SAMPLE_W-1:0] old_eff;
    logic signed [SQ_W-1:0]     sq_old_c;
    logic signed [SQ_W-1:0]     sq_new_c;
    logic signed [SUM_W-1:0]    neg_sum;
    logic [MAG_W-1:0]           mag_c;
    logic [CMP_W-1:0]           spread_c;

    // Read-first ring buffer: the entry being overwritten comes out registered.
    always_ff @(posedge clk)
    begin
        if (ctrl.accept)
        begin
            old_reg                <= hist_mem[ctrl.pos];
            hist_mem[ctrl.pos]     <= sample;
            new_reg                <= sample;
            full_reg               <= ctrl.full_before;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= ctrl.accept;
            v2_reg <= v1_reg;
        end
    end

    // The oldest sample only leaves the sums once the window is full.
    assign old_eff  = full_reg ? old_reg : '0;
    assign sq_old_c = old_eff * old_eff;
    assign sq_new_c = new_reg * new_reg;

    always_ff @(posedge clk)
    begin
        old2_reg   <= old_eff;
        new2_reg   <= new_reg;
        sq_old_reg <= unsigned'(sq_old_c);
        sq_new_reg <= unsigned'(sq_new_c);
    end

    assign sum_next   = sum_reg - SUM_W'(old2_reg) + SUM_W'(new2_reg);
    assign sumsq_next = sumsq_reg - SQS_W'(sq_old_reg) + SQS_W'(sq_new_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg   <= '0;
            sumsq_reg <= '0;
        end
        else if (v2_reg)
        begin
            sum_reg   <= sum_next;
            sumsq_reg <= sumsq_next;
        end
    end

    assign neg_sum = -sum_reg;
    assign mag_c   = sum_reg[SUM_W-1] ? neg_sum[MAG_W-1:0] : sum_reg[MAG_W-1:0];

    always_ff @(posedge clk)
    begin
        scaled_reg <= SCALED_W'(sumsq_reg) * SCALED_W'(WINDOW);
        magsq_reg  <= mag_c * mag_c;
    end

    assign spread_c = (CMP_W'(scaled_reg) > CMP_W'(magsq_reg))
                    ? (CMP_W'(scaled_reg) - CMP_W'(magsq_reg)) : '0;

    always_ff @(posedge clk)
    begin
        steady_reg <= spread_c < CMP_W'(bound_sq);
    end

    assign steady = steady_reg;

endmodule

FILE: rtl/fsd_out_fifo.sv
// ----------------------------------------------------------------------------
// fsd_out_fifo: result queue of the stillness detector
// Holds finished result items so the lanes keep running while the
// receiver stalls.
// ----------------------------------------------------------------------------
module fsd_out_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  fsd_pkg::out_item_t  wr_data,
    output logic                rd_valid,
    input  logic                rd_stall,
    output fsd_pkg::out_item_t  rd_data
);
    import fsd_pkg::*;

    out_item_t             entry_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [FIFO_CNT_W-1:0] count_reg;
    logic                  rd_en;

    assign rd_valid = (count_reg != '0);
    assign rd_data  = entry_mem[rd_ptr_reg];
    assign rd_en    = rd_valid && !rd_stall;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_mem[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= (wr_ptr_reg == FIFO_PTR_W'(FIFO_DEPTH - 1))
                            ? '0 : wr_ptr_reg + 1'b1;
            end
            if (rd_en)
            begin
                rd_ptr_reg <= (rd_ptr_reg == FIFO_PTR_W'(FIFO_DEPTH - 1))
                            ? '0 : rd_ptr_reg + 1'b1;
            end
            if (wr_en && !rd_en)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (rd_en && !wr_en)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule
